>>> design/lbs_pkg.sv
// Shared constants, types and command encoding for the two-bone skinning block.
// No dependencies; every other file of the block but lbs_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lbs_pkg;

  // Palette geometry. Each bone holds a 3x4 row-major affine matrix.
  localparam int NUM_BONES      = 16;
  localparam int BONE_AW        = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
  localparam int ELEMS_PER_BONE = 12;
  localparam int MAT_ROWS       = 3;
  localparam int MAT_COLS       = 4;
  localparam int LIN_COLS       = MAT_COLS - 1;

  // Field widths of the channels.
  localparam int BONE_W   = 4;
  localparam int SLOT_W   = 4;
  localparam int WEIGHT_W = 17;
  localparam int COORD_W  = 32;
  localparam int FRAC_W   = 16;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);

  // Command queue between the front and back ends.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Datapath widths, each just wide enough for its worst-case value.
  localparam int PROD_W  = 2 * COORD_W;               // element times coordinate
  localparam int RSUM_W  = PROD_W + 1;                // sum of three products
  localparam int POS_W   = RSUM_W - FRAC_W + 1;       // transformed coordinate
  localparam int HI_W    = POS_W - FRAC_W;            // integer part of it
  localparam int HPROD_W = HI_W + WEIGHT_W + 1;       // weight times integer part
  localparam int LPROD_W = FRAC_W + WEIGHT_W;         // weight times fraction
  localparam int HSUM_W  = HPROD_W + 1;
  localparam int LSUM_W  = LPROD_W + 1;
  localparam int RES_W   = HSUM_W + 1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SKIN  = 1'b1
  } op_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    logic                is_skin;
    logic                wr_ok;
    logic [BONE_AW-1:0]  wr_bone;
    logic [SLOT_W-1:0]   wr_slot;
    coord_t              wr_value;
    logic [BONE_AW-1:0]  bone_a;
    logic [BONE_AW-1:0]  bone_b;
    logic                zero_a;
    logic                zero_b;
    logic [WEIGHT_W-1:0] mix_a;
    logic [WEIGHT_W-1:0] mix_b;
    coord_t              bind_x;
    coord_t              bind_y;
    coord_t              bind_z;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage

`default_nettype wire

>>> design/lbs_channel_if.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on lbs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lbs_in_if import lbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [BONE_W-1:0]   write_bone;
  logic [SLOT_W-1:0]   element_slot;
  logic signed [COORD_W-1:0] element_value;
  logic [BONE_W-1:0]   first_bone;
  logic [BONE_W-1:0]   second_bone;
  logic [WEIGHT_W-1:0] first_weight;
  logic signed [COORD_W-1:0] bind_x;
  logic signed [COORD_W-1:0] bind_y;
  logic signed [COORD_W-1:0] bind_z;

  modport source (
    output valid, operation, write_bone, element_slot, element_value,
    output first_bone, second_bone, first_weight, bind_x, bind_y, bind_z,
    input  ready
  );
  modport sink (
    input  valid, operation, write_bone, element_slot, element_value,
    input  first_bone, second_bone, first_weight, bind_x, bind_y, bind_z,
    output ready
  );
endinterface

interface lbs_out_if import lbs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] skinned_x;
  logic signed [COORD_W-1:0] skinned_y;
  logic signed [COORD_W-1:0] skinned_z;

  modport source (output valid, skinned_x, skinned_y, skinned_z, input ready);
  modport sink   (input  valid, skinned_x, skinned_y, skinned_z, output ready);
endinterface

`default_nettype wire

>>> design/lbs_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lbs_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

>>> design/lbs_front.sv
// Front end: checks and classifies each incoming request into a queue command.
// Depends on lbs_pkg and lbs_in_if.
`timescale 1ns / 1ps
`default_nettype none

module lbs_front import lbs_pkg::*; (
  lbs_in_if.sink   in_chan,
  input  logic     queue_full,
  output cmd_req_t push_req
);

  logic [WEIGHT_W-1:0] weight_sat;

  assign in_chan.ready = !queue_full;

  // A weight above one counts as exactly one.
  assign weight_sat = (in_chan.first_weight > ONE_Q16) ? ONE_Q16 : in_chan.first_weight;

  always_comb begin
    push_req.valid        = in_chan.valid && !queue_full;
    push_req.cmd.is_skin  = (in_chan.operation == OP_SKIN);
    push_req.cmd.wr_ok    = (int'(in_chan.write_bone) < NUM_BONES) &&
                            (int'(in_chan.element_slot) < ELEMS_PER_BONE);
    push_req.cmd.wr_bone  = BONE_AW'(in_chan.write_bone);
    push_req.cmd.wr_slot  = in_chan.element_slot;
    push_req.cmd.wr_value = in_chan.element_value;
    push_req.cmd.bone_a   = BONE_AW'(in_chan.first_bone);
    push_req.cmd.bone_b   = BONE_AW'(in_chan.second_bone);
    // A bone outside the palette behaves as an all-zero matrix.
    push_req.cmd.zero_a   = !(int'(in_chan.first_bone) < NUM_BONES);
    push_req.cmd.zero_b   = !(int'(in_chan.second_bone) < NUM_BONES);
    push_req.cmd.mix_a    = weight_sat;
    push_req.cmd.mix_b    = ONE_Q16 - weight_sat;
    push_req.cmd.bind_x   = in_chan.bind_x;
    push_req.cmd.bind_y   = in_chan.bind_y;
    push_req.cmd.bind_z   = in_chan.bind_z;
  end

endmodule

`default_nettype wire

>>> design/lbs_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on lbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbs_queue import lbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_req_t push_req,
  output logic     full,
  input  logic     pop,
  output cmd_req_t head
);

  cmd_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r;
  logic [QUEUE_CW-1:0] count_nxt;
  logic                push;

  function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
    ptr_inc = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign push       = push_req.valid && !full;
  assign head.valid = (count_r != '0);
  assign head.cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_req.cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

>>> design/lbs_back.sv
// Back end: matrix palette memories, skinning and blend pipeline, result register.
// Depends on lbs_pkg, lbs_out_if and lbs_ram.
`timescale 1ns / 1ps
`default_nettype none

module lbs_back import lbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_req_t  head,
  output logic      pop,
  lbs_out_if.source out_chan
);

  logic advance;
  logic pal_we;

  logic [COORD_W-1:0] ram_a [ELEMS_PER_BONE];
  logic [COORD_W-1:0] ram_b [ELEMS_PER_BONE];
  coord_t             mat [2][ELEMS_PER_BONE];

  // Stage 1: palette read data arrives alongside the vertex and weights.
  logic                s1_valid_r;
  logic                s1_zero_r [2];
  logic [WEIGHT_W-1:0] s1_w_r [2];
  coord_t              s1_vec_r [LIN_COLS];

  // Stage 2: element-by-coordinate products.
  logic                      s2_valid_r;
  logic [WEIGHT_W-1:0]       s2_w_r [2];
  logic signed [PROD_W-1:0]  s2_prod_r   [2][MAT_ROWS][LIN_COLS];
  logic signed [PROD_W-1:0]  s2_prod_nxt [2][MAT_ROWS][LIN_COLS];
  coord_t                    s2_trans_r   [2][MAT_ROWS];
  coord_t                    s2_trans_nxt [2][MAT_ROWS];

  // Stage 3: row sums.
  logic                      s3_valid_r;
  logic [WEIGHT_W-1:0]       s3_w_r [2];
  logic signed [RSUM_W-1:0]  s3_sum_r   [2][MAT_ROWS];
  logic signed [RSUM_W-1:0]  s3_sum_nxt [2][MAT_ROWS];
  coord_t                    s3_trans_r [2][MAT_ROWS];

  // Stage 4: transformed coordinates in Q16.16.
  logic                      s4_valid_r;
  logic [WEIGHT_W-1:0]       s4_w_r [2];
  logic signed [POS_W-1:0]   s4_pos_r   [2][MAT_ROWS];
  logic signed [POS_W-1:0]   s4_pos_nxt [2][MAT_ROWS];

  // Stage 5: weighted integer and fraction parts.
  logic                      s5_valid_r;
  logic signed [HPROD_W-1:0] s5_hprod_r   [2][MAT_ROWS];
  logic signed [HPROD_W-1:0] s5_hprod_nxt [2][MAT_ROWS];
  logic [LPROD_W-1:0]        s5_lprod_r   [2][MAT_ROWS];
  logic [LPROD_W-1:0]        s5_lprod_nxt [2][MAT_ROWS];

  // Stage 6: blend sums.
  logic                      s6_valid_r;
  logic signed [HSUM_W-1:0]  s6_hsum_r   [MAT_ROWS];
  logic signed [HSUM_W-1:0]  s6_hsum_nxt [MAT_ROWS];
  logic [LSUM_W-1:0]         s6_lsum_r   [MAT_ROWS];
  logic [LSUM_W-1:0]         s6_lsum_nxt [MAT_ROWS];

  // Output register.
  logic                      out_valid_r;
  logic signed [RES_W-1:0]   res [MAT_ROWS];
  logic signed [RES_W-1:0]   frac_carry [MAT_ROWS];
  coord_t                    out_nxt [MAT_ROWS];
  coord_t                    out_r   [MAT_ROWS];

  function automatic coord_t sat_coord(input logic signed [RES_W-1:0] v);
    coord_t r;
    if (v[RES_W-1:COORD_W-1] == '0 || v[RES_W-1:COORD_W-1] == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[RES_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // The whole pipeline moves together; it freezes only when the result
  // register is full and not being taken.
  assign advance = !out_valid_r || out_chan.ready;
  assign pop     = head.valid && advance;
  assign pal_we  = pop && !head.cmd.is_skin && head.cmd.wr_ok;

  // One memory per matrix element, each read for both bones at once.
  for (genvar k = 0; k < ELEMS_PER_BONE; k++) begin : g_slot
    lbs_ram #(
      .WIDTH (COORD_W),
      .DEPTH (NUM_BONES)
    ) u_ram (
      .clk     (clk),
      .we      (pal_we && (head.cmd.wr_slot == SLOT_W'(k))),
      .waddr   (head.cmd.wr_bone),
      .wdata   (head.cmd.wr_value),
      .re      (advance),
      .raddr_a (head.cmd.bone_a),
      .raddr_b (head.cmd.bone_b),
      .rdata_a (ram_a[k]),
      .rdata_b (ram_b[k])
    );

    assign mat[0][k] = s1_zero_r[0] ? '0 : ram_a[k];
    assign mat[1][k] = s1_zero_r[1] ? '0 : ram_b[k];
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      for (int r = 0; r < MAT_ROWS; r++) begin
        for (int c = 0; c < LIN_COLS; c++) begin
          s2_prod_nxt[b][r][c] = mat[b][r*MAT_COLS + c] * s1_vec_r[c];
        end
        s2_trans_nxt[b][r] = mat[b][r*MAT_COLS + LIN_COLS];
        s3_sum_nxt[b][r]   = RSUM_W'(s2_prod_r[b][r][0]) + RSUM_W'(s2_prod_r[b][r][1]) +
                             RSUM_W'(s2_prod_r[b][r][2]);
        // Floor of the row sum in Q16.16, then the translation.
        s4_pos_nxt[b][r]   = POS_W'(s3_sum_r[b][r] >>> FRAC_W) + POS_W'(s3_trans_r[b][r]);
        s5_hprod_nxt[b][r] = $signed(s4_pos_r[b][r][POS_W-1:FRAC_W]) *
                             $signed({1'b0, s4_w_r[b]});
        s5_lprod_nxt[b][r] = s4_pos_r[b][r][FRAC_W-1:0] * s4_w_r[b];
      end
    end
    for (int r = 0; r < MAT_ROWS; r++) begin
      s6_hsum_nxt[r] = HSUM_W'(s5_hprod_r[0][r]) + HSUM_W'(s5_hprod_r[1][r]);
      s6_lsum_nxt[r] = LSUM_W'(s5_lprod_r[0][r]) + LSUM_W'(s5_lprod_r[1][r]);
      frac_carry[r]  = RES_W'(s6_lsum_r[r][LSUM_W-1:FRAC_W]);
      res[r]         = RES_W'(s6_hsum_r[r]) + frac_carry[r];
      out_nxt[r]     = sat_coord(res[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= pop && head.cmd.is_skin;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      out_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_zero_r[0] <= head.cmd.zero_a;
      s1_zero_r[1] <= head.cmd.zero_b;
      s1_w_r[0]    <= head.cmd.mix_a;
      s1_w_r[1]    <= head.cmd.mix_b;
      s1_vec_r[0]  <= head.cmd.bind_x;
      s1_vec_r[1]  <= head.cmd.bind_y;
      s1_vec_r[2]  <= head.cmd.bind_z;
      s2_w_r       <= s1_w_r;
      s2_prod_r    <= s2_prod_nxt;
      s2_trans_r   <= s2_trans_nxt;
      s3_w_r       <= s2_w_r;
      s3_sum_r     <= s3_sum_nxt;
      s3_trans_r   <= s2_trans_r;
      s4_w_r       <= s3_w_r;
      s4_pos_r     <= s4_pos_nxt;
      s5_hprod_r   <= s5_hprod_nxt;
      s5_lprod_r   <= s5_lprod_nxt;
      s6_hsum_r    <= s6_hsum_nxt;
      s6_lsum_r    <= s6_lsum_nxt;
      out_r        <= out_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.skinned_x = out_r[0];
  assign out_chan.skinned_y = out_r[1];
  assign out_chan.skinned_z = out_r[2];

  a_skin_enters: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.cmd.is_skin |=> s1_valid_r)
    else $error("popped skin request did not enter the pipeline");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !head.cmd.is_skin |=> !s1_valid_r)
    else $error("palette write entered the result pipeline");

endmodule

`default_nettype wire

>>> design/two_bone_linear_blend_skinning_top.sv
// Top level of the two-bone linear blend skinning block.
// Depends on lbs_pkg, lbs_channel_if, lbs_front, lbs_queue, lbs_back and lbs_ram.
//
// Usage:
//   Requests arrive on in_chan (valid/ready). A request with operation 0
//   writes one element of one bone's 3x4 skin matrix and gives no result.
//   A request with operation 1 skins a bind-pose vertex with two bones and
//   a Q1.16 weight, and gives one result on out_chan (valid/ready) holding
//   the blended, saturated Q16.16 position. Results leave in request order.
//
//   Throughput is one request per cycle while out_chan is not stalling, set
//   by the fully pipelined back end: each of the twelve palette memories
//   reads both bones at once. A request waits in the queue, is popped as the
//   palette is read, then passes through registers for the products, row
//   sums, Q16.16 flooring, weighting, the blend sums and the final carry
//   add with saturation into the result register.
//   A palette write is visible to any skin request accepted after it.
//
//   Reset (rst_n low, synchronous) empties the queue and the pipeline. The
//   palette is not cleared: it must be written before any bone is used.
//   When out_chan stalls, the pipeline freezes and the four-entry queue
//   keeps accepting requests until it fills, then in_chan.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module two_bone_linear_blend_skinning_top import lbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lbs_in_if.sink    in_chan,
  lbs_out_if.source out_chan
);

  // Classified request pushed by the front end into the queue.
  cmd_req_t push_req;
  // Oldest queued request, seen by the back end.
  cmd_req_t head;
  logic     queue_full;
  logic     pop;

  lbs_front u_front (
    .in_chan    (in_chan),
    .queue_full (queue_full),
    .push_req   (push_req)
  );

  lbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (push_req),
    .full     (queue_full),
    .pop      (pop),
    .head     (head)
  );

  // The back end pops only when its pipeline can advance, so a stalled
  // receiver backs up into the queue rather than dropping results.
  lbs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

>>> tb/two_bone_linear_blend_skinning_top_test.sv
// Self-checking testbench for the two-bone linear blend skinning block.
// Depends on lbs_pkg, the lbs_in_if/lbs_out_if channel interfaces and the block's top level.
// It keeps its own copy of the bone palette and predicts every skinned vertex.
`timescale 1ns / 1ps

module two_bone_linear_blend_skinning_top_test;
  import lbs_pkg::*;

  // Random requests after the directed part.
  localparam int RANDOM_REQUESTS  = 1600;
  // Once this few requests are still pending, both sides stop idling.
  localparam int CALM_TAIL        = 200;
  // The one long result-side stall, and when in the run it starts.
  localparam int LONG_HOLD_CYCLES = 100;
  localparam int LONG_HOLD_AT     = 200;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT      = 2000;
  // Settling time after the last result.
  localparam int DRAIN_CYCLES     = 30;

  localparam coord_t Q_ONE = 32'sh0001_0000;
  localparam coord_t C_MAX = 32'sh7FFF_FFFF;
  localparam coord_t C_MIN = 32'sh8000_0000;

  // One request as the sender puts it on the input channel.
  typedef struct {
    op_e                 op;
    logic [BONE_W-1:0]   write_bone;
    logic [SLOT_W-1:0]   element_slot;
    coord_t              element_value;
    logic [BONE_W-1:0]   first_bone;
    logic [BONE_W-1:0]   second_bone;
    logic [WEIGHT_W-1:0] first_weight;
    coord_t              bind_x;
    coord_t              bind_y;
    coord_t              bind_z;
    bit                  drain_first;  // wait for every outstanding result first
  } request_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } skinned_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lbs_in_if  in_chan ();
  lbs_out_if out_chan ();

  two_bone_linear_blend_skinning_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be offered, and skinned vertices the block still owes us.
  request_t request_queue[$];
  skinned_t skinned_due[$];

  // Our own copy of the skin matrix palette, updated as write requests are accepted.
  coord_t palette_copy [NUM_BONES][ELEMS_PER_BONE];

  request_t    on_bus;
  skinned_t    oldest;
  int unsigned tx_gap           = 0;
  int unsigned rx_hold          = 0;
  bit          tx_jitter        = 1'b1;
  bit          rx_jitter        = 1'b1;
  bit          long_hold_done   = 1'b0;
  bit          long_hold_active = 1'b0;
  int unsigned results_seen     = 0;
  int unsigned mismatches       = 0;
  int unsigned quiet_cycles     = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // One row of the bone matrix applied to the bind vertex, in Q16.16. The three
  // products are summed exactly and floored once, then the translation is added.
  function automatic logic signed [127:0] bone_row(logic [BONE_W-1:0] bone, int row,
                                                   coord_t vx, coord_t vy, coord_t vz);
    logic signed [127:0] dot;
    dot = palette_copy[bone][4*row]   * vx +
          palette_copy[bone][4*row+1] * vy +
          palette_copy[bone][4*row+2] * vz;
    return (dot >>> FRAC_W) + palette_copy[bone][4*row+3];
  endfunction

  // Weighted blend of both bones' transforms, floored and clamped to 32 bits.
  function automatic skinned_t skin_vertex(request_t rq);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] pa;
    logic signed [127:0] pb;
    logic signed [127:0] blend;
    coord_t              lane [MAT_ROWS];
    skinned_t            res;
    int                  r;
    // A weight above one counts as exactly one.
    wa = (rq.first_weight > ONE_Q16) ? ONE_Q16 : rq.first_weight;
    wb = 128'sd65536 - wa;
    for (r = 0; r < MAT_ROWS; r++) begin
      pa    = bone_row(rq.first_bone, r, rq.bind_x, rq.bind_y, rq.bind_z);
      pb    = bone_row(rq.second_bone, r, rq.bind_x, rq.bind_y, rq.bind_z);
      blend = (wa * pa + wb * pb) >>> FRAC_W;
      if (blend > 128'sd2147483647) begin
        lane[r] = C_MAX;
      end else if (blend < -128'sd2147483648) begin
        lane[r] = C_MIN;
      end else begin
        lane[r] = blend[COORD_W-1:0];
      end
    end
    res.x = lane[0];
    res.y = lane[1];
    res.z = lane[2];
    return res;
  endfunction

  // An accepted request either updates the palette copy or owes one result.
  // Writes to slots past the end of the matrix are dropped by the block.
  task automatic take_request(request_t rq);
    if (rq.op == OP_WRITE) begin
      if (rq.element_slot < ELEMS_PER_BONE) begin
        palette_copy[rq.write_bone][rq.element_slot] = rq.element_value;
      end
    end else begin
      skinned_due.push_back(skin_vertex(rq));
    end
  endtask

  task automatic compare_coord(string axis, coord_t want, coord_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, axis, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Fields that the operation does not use carry random junk, so the block is
  // shown to ignore them.
  task automatic queue_write(logic [BONE_W-1:0] bone, logic [SLOT_W-1:0] slot, coord_t value);
    request_t rq;
    rq.op            = OP_WRITE;
    rq.write_bone    = bone;
    rq.element_slot  = slot;
    rq.element_value = value;
    rq.first_bone    = BONE_W'($urandom);
    rq.second_bone   = BONE_W'($urandom);
    rq.first_weight  = WEIGHT_W'($urandom);
    rq.bind_x        = $urandom;
    rq.bind_y        = $urandom;
    rq.bind_z        = $urandom;
    rq.drain_first   = 1'b0;
    request_queue.push_back(rq);
  endtask

  task automatic queue_skin(logic [BONE_W-1:0] bone_a, logic [BONE_W-1:0] bone_b,
                            logic [WEIGHT_W-1:0] weight, coord_t vx, coord_t vy, coord_t vz);
    request_t rq;
    rq.op            = OP_SKIN;
    rq.write_bone    = BONE_W'($urandom);
    rq.element_slot  = SLOT_W'($urandom);
    rq.element_value = $urandom;
    rq.first_bone    = bone_a;
    rq.second_bone   = bone_b;
    rq.first_weight  = weight;
    rq.bind_x        = vx;
    rq.bind_y        = vy;
    rq.bind_z        = vz;
    rq.drain_first   = 1'b0;
    request_queue.push_back(rq);
  endtask

  // Mostly moderate values within +-4.0 so results rarely clamp, with a share
  // of extremes and of fully random words.
  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return coord_t'($urandom_range(0, 2)) - 32'sd1;
      3, 4:    return $urandom;
      default: return coord_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers one request at a time and holds it until it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        take_request(on_bus);
      end
      // Idling comes and goes in stretches.
      if ($urandom_range(0, 99) == 0) begin
        tx_jitter <= !tx_jitter;
      end
      if (in_chan.valid && !in_chan.ready) begin
        // The block is stalling us; the request stays on the bus unchanged.
      end else if (tx_gap != 0) begin
        tx_gap        <= tx_gap - 1;
        in_chan.valid <= 1'b0;
      end else if (request_queue.size() == 0 ||
                   (request_queue[0].drain_first && skinned_due.size() != 0)) begin
        in_chan.valid <= 1'b0;
      end else if (tx_jitter && !long_hold_active && request_queue.size() > CALM_TAIL &&
                   $urandom_range(0, 4) == 0) begin
        in_chan.valid <= 1'b0;
        tx_gap        <= $urandom_range(0, 2);
      end else begin
        on_bus = request_queue.pop_front();
        in_chan.valid         <= 1'b1;
        in_chan.operation     <= on_bus.op;
        in_chan.write_bone    <= on_bus.write_bone;
        in_chan.element_slot  <= on_bus.element_slot;
        in_chan.element_value <= on_bus.element_value;
        in_chan.first_bone    <= on_bus.first_bone;
        in_chan.second_bone   <= on_bus.second_bone;
        in_chan.first_weight  <= on_bus.first_weight;
        in_chan.bind_x        <= on_bus.bind_x;
        in_chan.bind_y        <= on_bus.bind_y;
        in_chan.bind_z        <= on_bus.bind_z;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result against the oldest prediction and drives ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready   <= 1'b0;
      rx_hold          <= 0;
      long_hold_active <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (skinned_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d %0d %0d", $time,
                   out_chan.skinned_x, out_chan.skinned_y, out_chan.skinned_z);
          mismatches++;
        end else begin
          oldest = skinned_due.pop_front();
          compare_coord("skinned_x", oldest.x, out_chan.skinned_x);
          compare_coord("skinned_y", oldest.y, out_chan.skinned_y);
          compare_coord("skinned_z", oldest.z, out_chan.skinned_z);
        end
        results_seen++;
      end
      if ($urandom_range(0, 99) == 0) begin
        rx_jitter <= !rx_jitter;
      end
      if (rx_hold != 0) begin
        rx_hold        <= rx_hold - 1;
        out_chan.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        // One long stall so the queue and pipeline fill and in_chan.ready drops,
        // while the driver keeps offering requests without gaps.
        long_hold_done   <= 1'b1;
        long_hold_active <= 1'b1;
        out_chan.ready   <= 1'b0;
        rx_hold          <= LONG_HOLD_CYCLES - 1;
      end else if (rx_jitter && request_queue.size() > CALM_TAIL &&
                   $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        rx_hold        <= $urandom_range(0, 2);
      end else begin
        out_chan.ready   <= 1'b1;
        long_hold_active <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any request or result moving means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results still due", $time,
                 STALL_LIMIT, skinned_due.size());
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int                  b;
    int                  s;
    int                  i;
    coord_t              value;
    logic [WEIGHT_W-1:0] w;

    in_chan.valid         = 1'b0;
    in_chan.operation     = OP_WRITE;
    in_chan.write_bone    = '0;
    in_chan.element_slot  = '0;
    in_chan.element_value = '0;
    in_chan.first_bone    = '0;
    in_chan.second_bone   = '0;
    in_chan.first_weight  = '0;
    in_chan.bind_x        = '0;
    in_chan.bind_y        = '0;
    in_chan.bind_z        = '0;
    out_chan.ready        = 1'b0;

    // The palette powers up undefined, so every element of every bone is written
    // before any skin request. Bone 0 is the identity, bone 1 the identity plus a
    // translation of (1.5, -2.0, 3.0), and the rest are random.
    for (b = 0; b < NUM_BONES; b++) begin
      for (s = 0; s < ELEMS_PER_BONE; s++) begin
        if (b < 2) begin
          case (s)
            0, 5, 10: value = Q_ONE;
            3:        value = (b == 1) ? 32'sh0001_8000 : '0;
            7:        value = (b == 1) ? -32'sh0002_0000 : '0;
            11:       value = (b == 1) ? 32'sh0003_0000 : '0;
            default:  value = '0;
          endcase
        end else begin
          value = random_coord();
        end
        queue_write(BONE_W'(b), SLOT_W'(s), value);
      end
    end

    // Weight sweep between two known bones: half, none, full, just above one
    // and the largest weight the field can carry.
    queue_skin(4'd0, 4'd1, 17'h0_8000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    queue_skin(4'd0, 4'd1, '0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    queue_skin(4'd0, 4'd1, ONE_Q16, -32'sh0001_0000, 32'sh0000_8000, 32'sh0003_0000);
    queue_skin(4'd0, 4'd1, ONE_Q16 + 17'd1, 32'sh0001_0000, 32'sh0002_0000, -32'sd1);
    queue_skin(4'd1, 4'd0, 17'h1_FFFF, 32'sh0005_0000, -32'sh0002_0000, 32'sh0000_0001);

    // Row 0 of bone 15 all at the top of the range: both clamping directions.
    queue_write(4'd15, 4'd0, C_MAX);
    queue_write(4'd15, 4'd1, C_MAX);
    queue_write(4'd15, 4'd2, C_MAX);
    queue_write(4'd15, 4'd3, C_MAX);
    queue_skin(4'd15, 4'd15, 17'h0_4000, C_MAX, C_MAX, C_MAX);
    queue_skin(4'd15, 4'd15, 17'h0_C000, C_MIN, C_MIN, C_MIN);

    // Most negative element times most negative coordinate.
    queue_write(4'd14, 4'd0, C_MIN);
    queue_skin(4'd14, 4'd0, 17'h0_8000, C_MIN, '0, C_MAX);

    // Writes past the last matrix slot must leave bone 2 untouched.
    queue_write(4'd2, 4'd12, C_MAX);
    queue_write(4'd2, 4'd15, C_MIN);
    queue_skin(4'd2, 4'd2, 17'h0_1234, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);

    // Same bone twice, the origin, and minus one in the last place.
    queue_skin(4'd3, 4'd3, 17'h0_7777, '0, '0, '0);
    queue_skin(4'd7, 4'd8, 17'h0_0001, -32'sd1, -32'sd1, -32'sd1);

    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        queue_write(BONE_W'($urandom_range(0, NUM_BONES - 1)),
                    ($urandom_range(0, 7) == 0) ? SLOT_W'($urandom_range(12, 15))
                                                : SLOT_W'($urandom_range(0, 11)),
                    random_coord());
      end else begin
        case ($urandom_range(0, 9))
          0:       w = '0;
          1:       w = ONE_Q16;
          2:       w = WEIGHT_W'($urandom_range(65537, 131071));
          default: w = WEIGHT_W'($urandom_range(0, 65536));
        endcase
        queue_skin(BONE_W'($urandom_range(0, NUM_BONES - 1)),
                   BONE_W'($urandom_range(0, NUM_BONES - 1)),
                   w, random_coord(), random_coord(), random_coord());
      end
      // Now and then the sender stops until the block has caught up completely.
      if (i == 600 || i == 1200) begin
        request_queue[$].drain_first = 1'b1;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled on the falling edge so the clocked processes have settled.
    do begin
      @(negedge clk);
    end while (request_queue.size() != 0 || in_chan.valid || skinned_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && skinned_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
design/lbs_pkg.sv
design/lbs_channel_if.sv
design/lbs_ram.sv
design/lbs_front.sv
design/lbs_queue.sv
design/lbs_back.sv
design/two_bone_linear_blend_skinning_top.sv
tb/two_bone_linear_blend_skinning_top_test.sv
